### sv/tmtp_pkg.sv
// Shared constants, types and helper functions for the track message text parser.
`timescale 1ns / 1ps

package tmtp_pkg;

   localparam int MAX_DATA_BYTES = 8;

   localparam int COL_W      = 6;
   localparam int HASH_W     = 16;
   localparam int CMD_W      = 8;
   localparam int LEN_W      = 4;
   localparam int DATA_W     = 8 * MAX_DATA_BYTES;
   localparam int BYTE_IDX_W = 5;
   localparam int SHIFT_W    = $clog2(DATA_W);

   localparam logic [COL_W-1:0] COL_LIMIT      = COL_W'(63);
   localparam logic [COL_W-1:0] MIN_LINE_LEN   = COL_W'(11);
   localparam logic [COL_W-1:0] DATA_START_COL = COL_W'(12);
   localparam logic [COL_W-1:0] RESPONSE_COL   = COL_W'(5);
   localparam logic [COL_W-1:0] CMD_HI_COL     = COL_W'(7);
   localparam logic [COL_W-1:0] CMD_LO_COL     = COL_W'(8);
   localparam logic [COL_W-1:0] LENGTH_COL     = COL_W'(10);
   localparam logic [COL_W-1:0] HASH_LAST_COL  = COL_W'(3);
   localparam logic [7:0]       SPACE_CODE     = 8'h20;

   typedef enum logic {
      REQ_CHAR = 1'b0,
      REQ_EOL  = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic       bad;
      logic [3:0] value;
   } hex_digit_type;

   typedef struct packed {
      logic [BYTE_IDX_W-1:0] idx;
      logic                  high_nibble;
      logic                  digit_col;
   } data_col_type;

   // Decode one ASCII hex digit; flag anything else as bad.
   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type d;
      d.bad   = 1'b0;
      d.value = 4'h0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d.value = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d.value = 4'(c - 8'h37);
      end else begin
         d.bad = 1'b1;
      end
      return d;
   endfunction

   // Split a data column offset into byte index and position; divide by 3 as
   // multiply by 43 and shift by 7, exact for offsets below 128.
   function automatic data_col_type data_col_decode(input logic [COL_W-1:0] rel);
      data_col_type r;
      logic [12:0]  prod;
      logic [COL_W:0] pos;
      prod          = 13'(rel) * 13'd43;
      r.idx         = BYTE_IDX_W'(prod >> 7);
      pos           = (COL_W+1)'(rel) - (COL_W+1)'(3 * r.idx);
      r.high_nibble = (pos == '0);
      r.digit_col   = (pos < (COL_W+1)'(2));
      return r;
   endfunction

endpackage

### sv/tmtp_ifs.sv
// Request and response channel interfaces for the track message text parser.
`timescale 1ns / 1ps

interface tmtp_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] char_code;

   modport source (output valid, output req_type, output char_code, input ready);
   modport sink (input valid, input req_type, input char_code, output ready);
endinterface

interface tmtp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          parse_ok;
   logic [tmtp_pkg::HASH_W-1:0]   hash_value;
   logic                          is_response;
   logic [tmtp_pkg::CMD_W-1:0]    command_code;
   logic [tmtp_pkg::LEN_W-1:0]    payload_length;
   logic [tmtp_pkg::DATA_W-1:0]   payload_bytes;

   modport source (output valid, output parse_ok, output hash_value, output is_response,
                   output command_code, output payload_length, output payload_bytes,
                   input ready);
   modport sink (input valid, input parse_ok, input hash_value, input is_response,
                 input command_code, input payload_length, input payload_bytes,
                 output ready);
endinterface

### sv/track_message_text_parser.sv
// Top level of the fixed-column track message text parser.
`timescale 1ns / 1ps

// Track message text parser. Feed a line one character per transaction on
// req_ch (req_type = 0, char_code = ASCII), then one end-of-line transaction
// (req_type = 1) to get exactly one response transaction on rsp_ch. Columns
// 0-3 carry a hex hash, a non-space at column 5 flags a response, columns 7-8
// the hex command, column 10 the hex payload length (at most 8), and data byte
// i sits at columns 12+3i and 13+3i. Characters past the needed columns are
// ignored. A short line, a length above 8, or a bad hex digit in any consumed
// column gives parse_ok = 0 with all other fields zero. Every transaction
// updates the line state at the accepting edge, and the end-of-line
// transaction loads the response register on that same edge, so one
// character per clock is sustained. The response register is the only
// buffer on the output side; req_ch stalls only while a finished response is
// still waiting and rsp_ch is not taking it in the same cycle.
module track_message_text_parser (
   input logic      clock,
   input logic      reset,
   tmtp_req_if.sink   req_ch,
   tmtp_rsp_if.source rsp_ch
);

   // Line state
   logic [tmtp_pkg::COL_W-1:0]  col_count_ff,  col_count_in;
   logic                        error_seen_ff, error_seen_in;
   logic [tmtp_pkg::HASH_W-1:0] hash_acc_ff,   hash_acc_in;
   logic                        resp_flag_ff,  resp_flag_in;
   logic [tmtp_pkg::CMD_W-1:0]  cmd_acc_ff,    cmd_acc_in;
   logic [tmtp_pkg::LEN_W-1:0]  len_acc_ff,    len_acc_in;
   logic [tmtp_pkg::DATA_W-1:0] data_store_ff, data_store_in;

   // Response register
   logic                        rsp_valid_ff,  rsp_valid_in;
   logic                        rsp_ok_ff,     rsp_ok_in;
   logic [tmtp_pkg::HASH_W-1:0] rsp_hash_ff,   rsp_hash_in;
   logic                        rsp_resp_ff,   rsp_resp_in;
   logic [tmtp_pkg::CMD_W-1:0]  rsp_cmd_ff,    rsp_cmd_in;
   logic [tmtp_pkg::LEN_W-1:0]  rsp_len_ff,    rsp_len_in;
   logic [tmtp_pkg::DATA_W-1:0] rsp_data_ff,   rsp_data_in;

   logic                          accept;
   logic                          is_eol;
   tmtp_pkg::hex_digit_type       digit;
   tmtp_pkg::data_col_type        dcol;
   logic [tmtp_pkg::COL_W-1:0]    rel_col;
   logic [tmtp_pkg::SHIFT_W-1:0]  nib_shift;
   logic                          line_ok;
   logic [tmtp_pkg::COL_W:0]      needed_len;

   // Accept whenever the response slot is free or is being drained this cycle.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_eol       = (req_ch.req_type == tmtp_pkg::REQ_EOL);

   assign digit     = tmtp_pkg::hex_decode(req_ch.char_code);
   assign rel_col   = col_count_ff - tmtp_pkg::DATA_START_COL;
   assign dcol      = tmtp_pkg::data_col_decode(rel_col);
   // Byte index is below MAX_DATA_BYTES whenever the shift is used.
   assign nib_shift = tmtp_pkg::SHIFT_W'({dcol.idx, 3'b000})
                      + (dcol.high_nibble ? tmtp_pkg::SHIFT_W'(4) : '0);

   // Line must be at least 11 characters long plus three columns per data byte.
   assign needed_len = (tmtp_pkg::COL_W+1)'(tmtp_pkg::MIN_LINE_LEN)
                       + (tmtp_pkg::COL_W+1)'({len_acc_ff, 1'b0})
                       + (tmtp_pkg::COL_W+1)'(len_acc_ff);
   assign line_ok = !error_seen_ff
                    && (col_count_ff >= tmtp_pkg::MIN_LINE_LEN)
                    && (32'(len_acc_ff) <= tmtp_pkg::MAX_DATA_BYTES)
                    && ((tmtp_pkg::COL_W+1)'(col_count_ff) >= needed_len);

   // Per-character column update
   always_comb begin
      col_count_in  = col_count_ff;
      error_seen_in = error_seen_ff;
      hash_acc_in   = hash_acc_ff;
      resp_flag_in  = resp_flag_ff;
      cmd_acc_in    = cmd_acc_ff;
      len_acc_in    = len_acc_ff;
      data_store_in = data_store_ff;

      if (accept && is_eol) begin
         // Clear for the next line
         col_count_in  = '0;
         error_seen_in = 1'b0;
         hash_acc_in   = '0;
         resp_flag_in  = 1'b0;
         cmd_acc_in    = '0;
         len_acc_in    = '0;
         data_store_in = '0;
      end else if (accept) begin
         if (col_count_ff <= tmtp_pkg::HASH_LAST_COL) begin
            if (digit.bad) begin
               error_seen_in = 1'b1;
            end else begin
               hash_acc_in = {hash_acc_ff[tmtp_pkg::HASH_W-5:0], digit.value};
            end
         end else if (col_count_ff == tmtp_pkg::RESPONSE_COL) begin
            resp_flag_in = (req_ch.char_code != tmtp_pkg::SPACE_CODE);
         end else if (col_count_ff == tmtp_pkg::CMD_HI_COL
                      || col_count_ff == tmtp_pkg::CMD_LO_COL) begin
            if (digit.bad) begin
               error_seen_in = 1'b1;
            end else begin
               cmd_acc_in = {cmd_acc_ff[tmtp_pkg::CMD_W-5:0], digit.value};
            end
         end else if (col_count_ff == tmtp_pkg::LENGTH_COL) begin
            if (digit.bad) begin
               error_seen_in = 1'b1;
            end else begin
               len_acc_in = digit.value;
            end
         end else if (col_count_ff >= tmtp_pkg::DATA_START_COL
                      && col_count_ff < tmtp_pkg::COL_LIMIT) begin
            // Consume only digits of bytes inside the announced length.
            if (dcol.digit_col
                && dcol.idx < tmtp_pkg::BYTE_IDX_W'(len_acc_ff)
                && 32'(dcol.idx) < tmtp_pkg::MAX_DATA_BYTES) begin
               if (digit.bad) begin
                  error_seen_in = 1'b1;
               end else begin
                  data_store_in = data_store_ff
                                  | (tmtp_pkg::DATA_W'(digit.value) << nib_shift);
               end
            end
         end

         // Saturate past the last column that matters
         if (col_count_ff < tmtp_pkg::COL_LIMIT) begin
            col_count_in = col_count_ff + 1'b1;
         end
      end
   end

   // Response register: load on end of line, drop once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_hash_in  = rsp_hash_ff;
      rsp_resp_in  = rsp_resp_ff;
      rsp_cmd_in   = rsp_cmd_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && is_eol) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = line_ok;
         rsp_hash_in  = line_ok ? hash_acc_ff   : '0;
         rsp_resp_in  = line_ok ? resp_flag_ff  : 1'b0;
         rsp_cmd_in   = line_ok ? cmd_acc_ff    : '0;
         rsp_len_in   = line_ok ? len_acc_ff    : '0;
         rsp_data_in  = line_ok ? data_store_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff  <= '0;
         error_seen_ff <= 1'b0;
         hash_acc_ff   <= '0;
         resp_flag_ff  <= 1'b0;
         cmd_acc_ff    <= '0;
         len_acc_ff    <= '0;
         data_store_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         col_count_ff  <= col_count_in;
         error_seen_ff <= error_seen_in;
         hash_acc_ff   <= hash_acc_in;
         resp_flag_ff  <= resp_flag_in;
         cmd_acc_ff    <= cmd_acc_in;
         len_acc_ff    <= len_acc_in;
         data_store_ff <= data_store_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Response payload holds without reset.
   always_ff @(posedge clock) begin
      rsp_ok_ff   <= rsp_ok_in;
      rsp_hash_ff <= rsp_hash_in;
      rsp_resp_ff <= rsp_resp_in;
      rsp_cmd_ff  <= rsp_cmd_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.parse_ok       = rsp_ok_ff;
   assign rsp_ch.hash_value     = rsp_hash_ff;
   assign rsp_ch.is_response    = rsp_resp_ff;
   assign rsp_ch.command_code   = rsp_cmd_ff;
   assign rsp_ch.payload_length = rsp_len_ff;
   assign rsp_ch.payload_bytes  = rsp_data_ff;

endmodule
